### sv/mbt4d_pkg.sv
// ----------------------------------------------------------------------------
// mbt4d_pkg
// shared types, constants and helpers of the 4-d maze backtracker
// ----------------------------------------------------------------------------
package mbt4d_pkg;

    localparam int MAX_SIDE  = 8;
    localparam int MAX_CELLS = 4096;
    localparam int SIDE_W    = $clog2(MAX_SIDE);
    localparam int IDX_W     = $clog2(MAX_CELLS);
    localparam int DEPTH_W   = IDX_W + 1;
    localparam int SREG_W    = 4;

    localparam logic [1:0] OP_SETUP = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;

    localparam logic [2:0] ACT_CARVED = 3'd0;
    localparam logic [2:0] ACT_BACK   = 3'd1;
    localparam logic [2:0] ACT_DONE   = 3'd2;
    localparam logic [2:0] ACT_SETUP  = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    typedef struct packed {
        logic             latch;
        logic             sweep_wr;
        logic             init_fin;
        logic             scan_rd;
        logic             mod_step;
        logic             pick;
        logic             rd_cur;
        logic             wr_cur;
        logic             rd_nb;
        logic             wr_nb;
        logic             rd_stk;
        logic             pop;
        logic             rd_q;
        logic             q_fin;
        logic             fin_idle;
        logic             emit;
        logic [IDX_W-1:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       count_zero;
        logic       n_zero;
        logic       depth_zero;
        logic       out_free;
    } t_stat;

    // a side of 0 counts as 1, above the maximum counts as the maximum
    function automatic logic [SREG_W-1:0] eff_side(input logic [SREG_W-1:0] s);
        logic [SREG_W-1:0] r;
        r = s;
        if (s == '0) begin
            r = SREG_W'(1);
        end else if (s > SREG_W'(MAX_SIDE)) begin
            r = SREG_W'(MAX_SIDE);
        end
        return r;
    endfunction

endpackage

### sv/maze_backtracker_4d.sv
// ----------------------------------------------------------------------------
// maze_backtracker_4d
// randomized depth-first maze builder on a four-dimensional room grid
// ----------------------------------------------------------------------------
// One request is worked at a time. Set-up is a sweep over all 4096 rooms
// through the single-port wall and visited memories, one room a cycle. A
// carving step does eight neighbour visited reads, an 8-step bit-serial
// remainder for the choice, then read-modify-write of two wall words. A
// step may instead backtrack, or meet no rooms left or a stuck walk.
// A response that would overwrite one still waiting holds the sequencer
// until it is taken. The next request is taken as soon as the response is
// registered, even while it still waits.
module maze_backtracker_4d import mbt4d_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [SREG_W-1:0] i_cfg_data,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_choice,
    input  logic [SIDE_W-1:0] i_query_x,
    input  logic [SIDE_W-1:0] i_query_y,
    input  logic [SIDE_W-1:0] i_query_z,
    input  logic [SIDE_W-1:0] i_query_w,
    input  logic [2:0]        i_edge_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output logic [2:0]        o_action,
    output logic [2:0]        o_direction,
    output logic [SIDE_W-1:0] o_room_x,
    output logic [SIDE_W-1:0] o_room_y,
    output logic [SIDE_W-1:0] o_room_z,
    output logic [SIDE_W-1:0] o_room_w,
    output logic              o_wall_present,
    output logic [7:0]        o_wall_mask,
    output logic [IDX_W-1:0]  o_cells_left,
    output logic              o_bad_position
);

    t_cmd  cmd;
    t_stat stat;

    mbt4d_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mbt4d_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_choice       (i_choice),
        .i_query_x      (i_query_x),
        .i_query_y      (i_query_y),
        .i_query_z      (i_query_z),
        .i_query_w      (i_query_w),
        .i_edge_req     (i_edge_req),
        .i_rsp_ready    (i_rsp_ready),
        .o_rsp_valid    (o_rsp_valid),
        .o_action       (o_action),
        .o_direction    (o_direction),
        .o_room_x       (o_room_x),
        .o_room_y       (o_room_y),
        .o_room_z       (o_room_z),
        .o_room_w       (o_room_w),
        .o_wall_present (o_wall_present),
        .o_wall_mask    (o_wall_mask),
        .o_cells_left   (o_cells_left),
        .o_bad_position (o_bad_position)
    );

`ifndef SYNTHESIS
    // busy right after a request is taken
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while previous one in flight");

    // read fields stay clear on walk and set-up responses
    a_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_action != ACT_READ) |->
            !o_bad_position && !o_wall_present && (o_wall_mask == 8'd0))
        else $error("read fields set on non-read response");

    // a bad position never reports walls
    a_bad_no_walls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_bad_position |-> (o_wall_mask == 8'd0) && !o_wall_present)
        else $error("walls reported for bad position");
`endif

endmodule

### sv/mbt4d_dpath.sv
// ----------------------------------------------------------------------------
// mbt4d_dpath
// room stores, path stack, walk registers and result register
// ----------------------------------------------------------------------------
module mbt4d_dpath import mbt4d_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [SREG_W-1:0]      i_cfg_data,
    input  logic [1:0]             i_opcode,
    input  logic [7:0]             i_choice,
    input  logic [SIDE_W-1:0]      i_query_x,
    input  logic [SIDE_W-1:0]      i_query_y,
    input  logic [SIDE_W-1:0]      i_query_z,
    input  logic [SIDE_W-1:0]      i_query_w,
    input  logic [2:0]             i_edge_req,
    input  logic                   i_rsp_ready,
    output logic                   o_rsp_valid,
    output logic [2:0]             o_action,
    output logic [2:0]             o_direction,
    output logic [SIDE_W-1:0]      o_room_x,
    output logic [SIDE_W-1:0]      o_room_y,
    output logic [SIDE_W-1:0]      o_room_z,
    output logic [SIDE_W-1:0]      o_room_w,
    output logic                   o_wall_present,
    output logic [7:0]             o_wall_mask,
    output logic [IDX_W-1:0]       o_cells_left,
    output logic                   o_bad_position
);

    logic [SREG_W-1:0]  r_side [4];
    logic [SREG_W-1:0]  eff [4];

    logic [7:0]         wall_mem [MAX_CELLS];
    logic               vis_mem  [MAX_CELLS];
    logic [IDX_W-1:0]   stk_mem  [MAX_CELLS];
    logic [7:0]         r_wall_q;
    logic               r_vis_q;
    logic [IDX_W-1:0]   r_stk_q;

    logic [IDX_W-1:0]   r_pos;
    logic [DEPTH_W-1:0] r_depth;
    logic [IDX_W-1:0]   r_count;
    logic [1:0]         r_op;
    logic [7:0]         r_choice;
    logic [SIDE_W-1:0]  r_q [4];
    logic [2:0]         r_edge;
    logic [7:0]         r_mask;
    logic               r_cap_en;
    logic               r_scan_ok;
    logic [2:0]         r_scan_d;
    logic [4:0]         r_rem;
    logic [2:0]         r_dir;
    logic [IDX_W-1:0]   r_nb;
    logic [2:0]         r_act;
    logic [7:0]         r_qmask;
    logic               r_qpres;
    logic               r_bad;
    logic [6:0]         r_pxy;
    logic [6:0]         r_pzw;

    logic [IDX_W:0]     scan_nb;
    logic [IDX_W:0]     pick_nb;
    logic [3:0]         n_cand;
    logic [2:0]         pick_dir;
    logic [4:0]         mod_t;
    logic [IDX_W-1:0]   start_idx;
    logic [IDX_W-1:0]   q_idx;
    logic               q_bad;
    logic [IDX_W:0]     prod;
    logic [IDX_W-1:0]   wall_addr;
    logic               wall_we;
    logic [7:0]         wall_wd;
    logic [IDX_W-1:0]   vis_addr;
    logic               vis_we;
    logic               vis_wd;
    logic               stk_we;
    logic [IDX_W-1:0]   stk_addr;
    logic [IDX_W-1:0]   depth_m1;

    // neighbour of pos along edge d: {in range, room index}
    function automatic logic [IDX_W:0] nb_calc(
        input logic [IDX_W-1:0]  pos,
        input logic [2:0]        d,
        input logic [SREG_W-1:0] e0,
        input logic [SREG_W-1:0] e1,
        input logic [SREG_W-1:0] e2,
        input logic [SREG_W-1:0] e3
    );
        logic [SIDE_W-1:0] c;
        logic [SREG_W-1:0] s;
        logic [SREG_W-1:0] nc;
        logic              ok;
        logic [IDX_W-1:0]  idx;
        c   = pos[(3 - d[2:1]) * SIDE_W +: SIDE_W];
        case (d[2:1])
            2'd0:    s = e0;
            2'd1:    s = e1;
            2'd2:    s = e2;
            default: s = e3;
        endcase
        if (!d[0]) begin
            nc = SREG_W'(c) - SREG_W'(1);
            ok = (c != '0) && (nc < s);
        end else begin
            nc = SREG_W'(c) + SREG_W'(1);
            ok = nc < s;
        end
        idx = pos;
        idx[(3 - d[2:1]) * SIDE_W +: SIDE_W] = nc[SIDE_W-1:0];
        return {ok, idx};
    endfunction

    always_comb begin
        for (int a = 0; a < 4; a++) begin
            eff[a] = eff_side(r_side[a]);
        end
    end

    assign scan_nb = nb_calc(r_pos, i_cmd.cnt[2:0], eff[0], eff[1], eff[2], eff[3]);
    assign pick_nb = nb_calc(r_pos, pick_dir, eff[0], eff[1], eff[2], eff[3]);

    always_comb begin
        n_cand = '0;
        for (int i = 0; i < 8; i++) begin
            n_cand = n_cand + 4'(r_mask[i]);
        end
    end

    // k-th candidate in edge order, k is the remainder
    always_comb begin
        logic [3:0] seen;
        logic       found;
        seen     = '0;
        found    = 1'b0;
        pick_dir = '0;
        for (int i = 0; i < 8; i++) begin
            if (r_mask[i] && !found) begin
                if (seen == r_rem[3:0]) begin
                    pick_dir = 3'(i);
                    found    = 1'b1;
                end
                seen = seen + 4'd1;
            end
        end
    end

    // restoring remainder, one choice bit a step, msb first
    always_comb begin
        logic [4:0] prev;
        prev  = (i_cmd.cnt[2:0] == 3'd0) ? 5'd0 : r_rem;
        mod_t = {prev[3:0], r_choice[3'd7 - i_cmd.cnt[2:0]]};
        if (mod_t >= {1'b0, n_cand}) begin
            mod_t = mod_t - {1'b0, n_cand};
        end
    end

    always_comb begin
        for (int a = 0; a < 4; a++) begin
            start_idx[(3 - a) * SIDE_W +: SIDE_W] = SIDE_W'(eff[a] - SREG_W'(1));
        end
    end

    assign q_idx = {r_q[0], r_q[1], r_q[2], r_q[3]};

    always_comb begin
        q_bad = 1'b0;
        for (int a = 0; a < 4; a++) begin
            if (SREG_W'(r_q[a]) >= eff[a]) begin
                q_bad = 1'b1;
            end
        end
    end

    assign prod     = (IDX_W + 1)'(r_pxy) * (IDX_W + 1)'(r_pzw);
    assign depth_m1 = IDX_W'(r_depth - DEPTH_W'(1));

    always_comb begin
        wall_addr = r_pos;
        wall_we   = 1'b0;
        wall_wd   = r_wall_q & ~(8'd1 << r_dir);
        if (i_cmd.sweep_wr) begin
            wall_addr = i_cmd.cnt;
            wall_we   = 1'b1;
            wall_wd   = 8'hFF;
        end else if (i_cmd.wr_cur) begin
            wall_we   = 1'b1;
        end else if (i_cmd.rd_nb || i_cmd.wr_nb) begin
            wall_addr = r_nb;
            wall_we   = i_cmd.wr_nb;
            wall_wd   = r_wall_q & ~(8'd1 << (r_dir ^ 3'd1));
        end else if (i_cmd.rd_q) begin
            wall_addr = q_idx;
        end
    end

    always_comb begin
        vis_addr = scan_nb[IDX_W-1:0];
        vis_we   = 1'b0;
        vis_wd   = 1'b1;
        if (i_cmd.sweep_wr) begin
            vis_addr = i_cmd.cnt;
            vis_we   = 1'b1;
            vis_wd   = 1'b0;
        end else if (i_cmd.init_fin) begin
            vis_addr = start_idx;
            vis_we   = 1'b1;
        end else if (i_cmd.wr_nb) begin
            vis_addr = r_nb;
            vis_we   = 1'b1;
        end
    end

    // push is skipped when the stack is full
    assign stk_we   = i_cmd.wr_cur && !r_depth[DEPTH_W-1];
    assign stk_addr = i_cmd.wr_cur ? r_depth[IDX_W-1:0] : depth_m1;

    always_ff @(posedge i_clk) begin
        if (wall_we) begin
            wall_mem[wall_addr] <= wall_wd;
        end
        r_wall_q <= wall_mem[wall_addr];
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            vis_mem[vis_addr] <= vis_wd;
        end
        r_vis_q <= vis_mem[vis_addr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_addr] <= r_pos;
        end
        r_stk_q <= stk_mem[stk_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 4; a++) begin
                r_side[a] <= SREG_W'(MAX_SIDE);
            end
        end else if (i_cfg_we) begin
            r_side[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_depth     <= '0;
            r_count     <= '0;
            r_cap_en    <= 1'b0;
            r_act       <= ACT_DONE;
            o_rsp_valid <= 1'b0;
        end else begin
            r_cap_en <= i_cmd.scan_rd;
            if (i_cmd.init_fin) begin
                r_pos   <= start_idx;
                r_count <= IDX_W'(prod - (IDX_W + 1)'(1));
                r_depth <= '0;
                r_act   <= ACT_SETUP;
            end
            if (i_cmd.wr_cur && !r_depth[DEPTH_W-1]) begin
                r_depth <= r_depth + DEPTH_W'(1);
            end
            if (i_cmd.wr_nb) begin
                r_pos   <= r_nb;
                r_count <= r_count - IDX_W'(1);
                r_act   <= ACT_CARVED;
            end
            if (i_cmd.pop) begin
                r_pos   <= r_stk_q;
                r_depth <= r_depth - DEPTH_W'(1);
                r_act   <= ACT_BACK;
            end
            if (i_cmd.fin_idle) begin
                r_act <= ACT_DONE;
            end
            if (i_cmd.q_fin) begin
                r_act <= ACT_READ;
            end
            if (i_cmd.emit) begin
                o_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                o_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pxy <= 7'(eff[0]) * 7'(eff[1]);
        r_pzw <= 7'(eff[2]) * 7'(eff[3]);
        if (i_cmd.latch) begin
            r_op     <= i_opcode;
            r_choice <= i_choice;
            r_q[0]   <= i_query_x;
            r_q[1]   <= i_query_y;
            r_q[2]   <= i_query_z;
            r_q[3]   <= i_query_w;
            r_edge   <= i_edge_req;
            r_mask   <= '0;
            r_dir    <= '0;
            r_qmask  <= '0;
            r_qpres  <= 1'b0;
            r_bad    <= 1'b0;
        end
        if (i_cmd.scan_rd) begin
            r_scan_ok <= scan_nb[IDX_W];
            r_scan_d  <= i_cmd.cnt[2:0];
        end
        if (r_cap_en) begin
            r_mask[r_scan_d] <= r_scan_ok && !r_vis_q;
        end
        if (i_cmd.mod_step) begin
            r_rem <= mod_t;
        end
        if (i_cmd.pick) begin
            r_dir <= pick_dir;
            r_nb  <= pick_nb[IDX_W-1:0];
        end
        if (i_cmd.q_fin) begin
            r_bad <= q_bad;
            if (!q_bad) begin
                r_qmask <= r_wall_q;
                r_qpres <= r_wall_q[r_edge];
            end
        end
        if (i_cmd.emit) begin
            o_action       <= r_act;
            o_direction    <= (r_act == ACT_CARVED) ? r_dir : 3'd0;
            o_wall_present <= r_qpres;
            o_wall_mask    <= r_qmask;
            o_bad_position <= r_bad;
            o_cells_left   <= r_count;
            if (r_act == ACT_READ) begin
                o_room_x <= r_q[0];
                o_room_y <= r_q[1];
                o_room_z <= r_q[2];
                o_room_w <= r_q[3];
            end else begin
                o_room_x <= r_pos[3 * SIDE_W +: SIDE_W];
                o_room_y <= r_pos[2 * SIDE_W +: SIDE_W];
                o_room_z <= r_pos[SIDE_W +: SIDE_W];
                o_room_w <= r_pos[0 +: SIDE_W];
            end
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.n_zero     = (n_cand == 4'd0);
    assign o_stat.depth_zero = (r_depth == '0);
    assign o_stat.out_free   = !o_rsp_valid || i_rsp_ready;

endmodule

### sv/mbt4d_ctrl.sv
// ----------------------------------------------------------------------------
// mbt4d_ctrl
// sequencer for set-up sweep, walk step and room read
// ----------------------------------------------------------------------------
module mbt4d_ctrl import mbt4d_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_SWEEP    = 5'd1;
    localparam logic [4:0] S_INIT     = 5'd2;
    localparam logic [4:0] S_SCAN     = 5'd3;
    localparam logic [4:0] S_SCAN_END = 5'd4;
    localparam logic [4:0] S_CHECK    = 5'd5;
    localparam logic [4:0] S_MOD      = 5'd6;
    localparam logic [4:0] S_PICK     = 5'd7;
    localparam logic [4:0] S_RD_CUR   = 5'd8;
    localparam logic [4:0] S_WR_CUR   = 5'd9;
    localparam logic [4:0] S_RD_NB    = 5'd10;
    localparam logic [4:0] S_WR_NB    = 5'd11;
    localparam logic [4:0] S_RD_STK   = 5'd12;
    localparam logic [4:0] S_POP      = 5'd13;
    localparam logic [4:0] S_RD_Q     = 5'd14;
    localparam logic [4:0] S_Q_FIN    = 5'd15;
    localparam logic [4:0] S_FINISH   = 5'd16;
    localparam logic [4:0] S_EMIT     = 5'd17;

    logic [4:0]       r_state;
    logic [4:0]       n_state;
    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] n_cnt;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + IDX_W'(1);
        o_cmd   = '0;
        o_cmd.cnt = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_RD_Q;
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_wr = 1'b1;
                if (r_cnt == IDX_W'(MAX_CELLS - 1)) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init_fin = 1'b1;
                n_state = S_EMIT;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (r_cnt == IDX_W'(7)) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_cnt = '0;
                if (!i_stat.n_zero) begin
                    n_state = S_MOD;
                end else if (!i_stat.depth_zero) begin
                    n_state = S_RD_STK;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (r_cnt == IDX_W'(7)) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state = S_RD_CUR;
            end
            S_RD_CUR: begin
                o_cmd.rd_cur = 1'b1;
                n_state = S_WR_CUR;
            end
            S_WR_CUR: begin
                o_cmd.wr_cur = 1'b1;
                n_state = S_RD_NB;
            end
            S_RD_NB: begin
                o_cmd.rd_nb = 1'b1;
                n_state = S_WR_NB;
            end
            S_WR_NB: begin
                o_cmd.wr_nb = 1'b1;
                n_state = S_EMIT;
            end
            S_RD_STK: begin
                o_cmd.rd_stk = 1'b1;
                n_state = S_POP;
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state = S_EMIT;
            end
            S_RD_Q: begin
                // the request was latched last cycle; branch on it here
                if (i_stat.op == OP_SETUP) begin
                    n_cnt   = '0;
                    n_state = S_SWEEP;
                end else if (i_stat.op == OP_STEP) begin
                    n_cnt   = '0;
                    n_state = i_stat.count_zero ? S_FINISH : S_SCAN;
                end else begin
                    // opcodes two and three are served as a read
                    o_cmd.rd_q = 1'b1;
                    n_state = S_Q_FIN;
                end
            end
            S_Q_FIN: begin
                o_cmd.q_fin = 1'b1;
                n_state = S_EMIT;
            end
            S_FINISH: begin
                o_cmd.fin_idle = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
